// File: design/nms_pkg.sv
// ----------------------------------------------------------------------------
// nms_pkg: shared types and constants for box non-maximum suppression
// box entry layout, ring sizing and fixed-point helpers
// ----------------------------------------------------------------------------
package nms_pkg;

  localparam int MAX_BOXES  = 64;
  localparam int IDX_W      = $clog2(MAX_BOXES);
  localparam int CNT_W      = $clog2(MAX_BOXES + 1);
  localparam int PIPE_DEPTH = 5;
  localparam int RING_LEN   = MAX_BOXES + PIPE_DEPTH;
  localparam int RND_W      = $clog2(RING_LEN);

  localparam int COORD_W = 13;
  localparam int SCORE_W = 16;
  localparam int SPAN_W  = 14;
  localparam int AREA_W  = 2 * SPAN_W;
  localparam int THR_W   = 16;
  localparam int PROD_W  = THR_W + AREA_W;

  localparam logic [1:0]         CFG_THRESHOLD = 2'd0;
  localparam logic [1:0]         CFG_MODE      = 2'd1;
  localparam logic [THR_W-1:0]   THR_RESET     = 16'd32768;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE
  } nms_state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
    logic [SCORE_W-1:0]        score;
    logic [IDX_W-1:0]          idx;
    logic                      valid;
    logic                      supp;
  } box_entry_t;

  // inclusive pixel span, zero when the box is empty
  function automatic logic [SPAN_W-1:0] span(input logic signed [COORD_W-1:0] lo,
                                             input logic signed [COORD_W-1:0] hi);
    logic signed [COORD_W+1:0] s;
    s = {{2{hi[COORD_W-1]}}, hi} - {{2{lo[COORD_W-1]}}, lo} + (COORD_W+2)'(1);
    span = (s <= 0) ? '0 : s[SPAN_W-1:0];
  endfunction

endpackage

// File: design/nms_cell.sv
// ----------------------------------------------------------------------------
// nms_cell: one slot of the box ring
// holds one box entry and takes its neighbor's entry on every shift
// ----------------------------------------------------------------------------
module nms_cell
  import nms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift_en,
  input  logic       clr,
  input  box_entry_t d,
  output box_entry_t q
);

  box_entry_t ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      ent_r.valid <= 1'b0;
      ent_r.supp  <= 1'b0;
    end else if (shift_en) begin
      ent_r.valid <= d.valid;
      ent_r.supp  <= d.supp;
    end
    if (shift_en) begin
      ent_r.left   <= d.left;
      ent_r.top    <= d.top;
      ent_r.right  <= d.right;
      ent_r.bottom <= d.bottom;
      ent_r.score  <= d.score;
      ent_r.idx    <= d.idx;
    end
  end

  assign q = ent_r;

endmodule

// File: design/nms_overlap.sv
// ----------------------------------------------------------------------------
// nms_overlap: pipelined overlap test against the selected box
// five ring slots; marks an entry suppressed when its overlap reaches threshold
// ----------------------------------------------------------------------------
module nms_overlap
  import nms_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             cmp_en,
  input  box_entry_t       sel,
  input  logic [THR_W-1:0] thr,
  input  logic             mode,
  input  box_entry_t       d,
  output box_entry_t       q
);

  box_entry_t e1_r, e2_r, e3_r, e4_r, e5_r;
  box_entry_t e5_nxt;
  logic hit1_r, hit2_r, hit3_r, hit4_r;
  logic self1_r, self2_r, self3_r, self4_r;

  logic [SPAN_W-1:0] wi_r, hi_r, wa_r, ha_r, wb_r, hb_r;
  logic [AREA_W-1:0] inter2_r, aa2_r, ab2_r;
  logic [AREA_W-1:0] inter3_r, den3_r;
  logic              dz3_r, dz4_r;
  logic [PROD_W-1:0] lhs4_r, prod4_r;

  logic signed [COORD_W-1:0] il, it, ir, ib;
  logic [AREA_W:0]           uni;
  logic [AREA_W-1:0]         den;

  always_comb begin
    il  = (d.left   > sel.left)   ? d.left   : sel.left;
    it  = (d.top    > sel.top)    ? d.top    : sel.top;
    ir  = (d.right  < sel.right)  ? d.right  : sel.right;
    ib  = (d.bottom < sel.bottom) ? d.bottom : sel.bottom;
    uni = {1'b0, aa2_r} + {1'b0, ab2_r} - {1'b0, inter2_r};
    if (mode) begin
      den = (aa2_r < ab2_r) ? aa2_r : ab2_r;
    end else begin
      den = uni[AREA_W-1:0];
    end
  end

  // stage 5 entry with the suppress decision folded in
  always_comb begin
    e5_nxt      = e4_r;
    e5_nxt.supp = e4_r.supp ||
                  (hit4_r && (self4_r || (!dz4_r && lhs4_r >= prod4_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r.valid <= 1'b0;
      e2_r.valid <= 1'b0;
      e3_r.valid <= 1'b0;
      e4_r.valid <= 1'b0;
      e5_r.valid <= 1'b0;
    end else if (adv) begin
      // stage 1: intersection edges and spans
      e1_r    <= d;
      hit1_r  <= d.valid && !d.supp && cmp_en;
      self1_r <= d.idx == sel.idx;
      wi_r    <= span(il, ir);
      hi_r    <= span(it, ib);
      wa_r    <= span(d.left, d.right);
      ha_r    <= span(d.top, d.bottom);
      wb_r    <= span(sel.left, sel.right);
      hb_r    <= span(sel.top, sel.bottom);
      // stage 2: areas
      e2_r     <= e1_r;
      hit2_r   <= hit1_r;
      self2_r  <= self1_r;
      inter2_r <= wi_r * hi_r;
      aa2_r    <= wa_r * ha_r;
      ab2_r    <= wb_r * hb_r;
      // stage 3: denominator
      e3_r     <= e2_r;
      hit3_r   <= hit2_r;
      self3_r  <= self2_r;
      inter3_r <= inter2_r;
      den3_r   <= den;
      dz3_r    <= den == '0;
      // stage 4: cross-multiplied threshold
      e4_r    <= e3_r;
      hit4_r  <= hit3_r;
      self4_r <= self3_r;
      dz4_r   <= dz3_r;
      lhs4_r  <= {inter3_r, 16'd0};
      prod4_r <= thr * den3_r;
      // stage 5: suppress decision
      e5_r <= e5_nxt;
    end
  end

  assign q = e5_r;

endmodule

// File: design/box_non_maximum_suppression.sv
// ----------------------------------------------------------------------------
// box_non_maximum_suppression: greedy nms over one set of scored boxes
// ring of box cells rotating through a shared pipelined overlap unit
// ----------------------------------------------------------------------------
// Boxes are taken one per cycle into a ring of MAX_BOXES (64) cells until the
// request with tlast; boxes beyond capacity are dropped and set_overflow is
// reported on every result of that set. Suppression then runs in rounds: in
// each round the whole ring (64 cells plus the 5 stages of the overlap unit)
// rotates once, so every box passes the overlap unit, is tested against the
// box chosen in the previous round and the best surviving box is tracked; a
// decide step follows. A set with K kept boxes therefore takes K + 1 rounds
// after its last box, plus any output stall. Input is not taken while a set
// is being suppressed. Config writes are always taken (cfg_ready high) and
// must only be made while the block is idle.
module box_non_maximum_suppression
  import nms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input boxes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // box_left, box_top, box_right, box_bottom, box_score
  input  logic        in_tlast,   // set_end
  // kept boxes
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // kept_left, kept_top, kept_right, kept_bottom, kept_score
  output logic        out_tlast,  // run_end
  output logic        out_tuser,  // set_overflow
  // config writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  nms_state_t state_r, state_nxt;

  logic [THR_W-1:0] thr_r;
  logic             mode_r;
  logic [CNT_W-1:0] box_count_r;
  logic             ovf_r;
  logic [RND_W-1:0] rnd_r;

  box_entry_t sel_r, best_r;
  logic       sel_valid_r, best_found_r;

  logic        out_valid_r;
  box_entry_t  out_box_r;
  logic        out_last_r, out_ovf_r;

  // control strobes
  logic in_acc, do_store, ring_shift, ring_clr, decide_go, round_end;

  box_entry_t new_ent, tail_in, pipe_out;
  box_entry_t cell_q [MAX_BOXES];
  logic       better;

  assign in_acc   = in_tvalid && in_tready;
  assign do_store = in_acc && (box_count_r < CNT_W'(MAX_BOXES));
  assign round_end = rnd_r == RND_W'(RING_LEN - 1);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:   if (in_acc && in_tlast) state_nxt = ST_SCAN;
      ST_SCAN:   if (round_end) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (decide_go) begin
          state_nxt = (!sel_valid_r || best_found_r) ? ST_SCAN : ST_LOAD;
        end
      end
      default:   state_nxt = ST_LOAD;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_tready  = 1'b0;
    ring_shift = 1'b0;
    ring_clr   = 1'b0;
    decide_go  = 1'b0;
    unique case (state_r)
      ST_LOAD:   begin
        in_tready  = 1'b1;
        ring_shift = do_store;
      end
      ST_SCAN:   ring_shift = 1'b1;
      ST_DECIDE: begin
        decide_go = !sel_valid_r || !out_valid_r;
        ring_clr  = decide_go && sel_valid_r && !best_found_r;
      end
      default:   in_tready = 1'b0;
    endcase
  end

  // new box from the input request
  always_comb begin
    new_ent.left   = in_tdata[12:0];
    new_ent.top    = in_tdata[25:13];
    new_ent.right  = in_tdata[38:26];
    new_ent.bottom = in_tdata[51:39];
    new_ent.score  = in_tdata[67:52];
    new_ent.idx    = box_count_r[IDX_W-1:0];
    new_ent.valid  = 1'b1;
    new_ent.supp   = 1'b0;
    tail_in = (state_r == ST_LOAD) ? new_ent : pipe_out;
  end

  // ring of cells: head feeds the overlap unit, tail takes its output or a new box
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    box_entry_t cell_d;
    if (i == MAX_BOXES - 1) begin : g_tail
      assign cell_d = tail_in;
    end else begin : g_mid
      assign cell_d = cell_q[i+1];
    end
    nms_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (ring_shift),
      .clr      (ring_clr),
      .d        (cell_d),
      .q        (cell_q[i])
    );
  end

  nms_overlap u_overlap (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (ring_shift && state_r == ST_SCAN),
    .cmp_en (sel_valid_r),
    .sel    (sel_r),
    .thr    (thr_r),
    .mode   (mode_r),
    .d      (cell_q[0]),
    .q      (pipe_out)
  );

  // best surviving box, earlier index wins a tie
  assign better = pipe_out.valid && !pipe_out.supp &&
                  (!best_found_r || pipe_out.score > best_r.score ||
                   (pipe_out.score == best_r.score && pipe_out.idx < best_r.idx));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      thr_r        <= THR_RESET;
      mode_r       <= 1'b0;
      box_count_r  <= '0;
      ovf_r        <= 1'b0;
      rnd_r        <= '0;
      sel_valid_r  <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_index == CFG_THRESHOLD) thr_r  <= cfg_data;
      if (cfg_valid && cfg_index == CFG_MODE)      mode_r <= cfg_data[0];

      if (do_store) box_count_r <= box_count_r + CNT_W'(1);
      if (in_acc && !do_store) ovf_r <= 1'b1;

      if (state_r == ST_SCAN) begin
        rnd_r <= round_end ? '0 : rnd_r + RND_W'(1);
        if (better) best_found_r <= 1'b1;
      end

      if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      if (decide_go) begin
        best_found_r <= 1'b0;
        if (sel_valid_r) out_valid_r <= 1'b1;
        if (!sel_valid_r || best_found_r) begin
          sel_valid_r <= 1'b1;
        end else begin
          // set finished
          sel_valid_r <= 1'b0;
          box_count_r <= '0;
          ovf_r       <= 1'b0;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN && better) best_r <= pipe_out;
    if (decide_go) begin
      sel_r <= best_r;
      if (sel_valid_r) begin
        out_box_r  <= sel_r;
        out_last_r <= !best_found_r;
        out_ovf_r  <= ovf_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_box_r.score, out_box_r.bottom, out_box_r.right,
                       out_box_r.top, out_box_r.left};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

// File: tb/nms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_checker: scoreboard for box non-maximum suppression
// tracks config writes and accepted boxes, predicts kept boxes per set
// ----------------------------------------------------------------------------
module nms_checker
  import nms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic        out_tlast,
  input  logic        out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          pending,
  output int          fail_count
);

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
    logic [SCORE_W-1:0]        score;
  } box_t;

  typedef struct packed {
    box_t box;
    logic run_end;
    logic overflow;
  } kept_t;

  box_t        set_boxes[MAX_BOXES];
  int          set_size;
  bit          set_dropped;
  logic [15:0] thr;
  bit          min_mode;
  kept_t       kept_q[$];

  assign pending = kept_q.size();

  // fields from the lowest bit up: left, top, right, bottom, score
  function automatic box_t unpack_box(logic [71:0] v);
    box_t b;
    b.left   = v[12:0];
    b.top    = v[25:13];
    b.right  = v[38:26];
    b.bottom = v[51:39];
    b.score  = v[67:52];
    return b;
  endfunction

  function automatic longint box_span(longint lo, longint hi);
    longint s;
    s = hi - lo + 1;
    return (s > 0) ? s : 0;
  endfunction

  function automatic longint area_of(box_t b);
    return box_span(b.left, b.right) * box_span(b.top, b.bottom);
  endfunction

  function automatic bit overlap_hits(box_t a, box_t b);
    longint l, t, r, d, inter, aa, ab, den;
    l = (a.left > b.left) ? a.left : b.left;
    t = (a.top > b.top) ? a.top : b.top;
    r = (a.right < b.right) ? a.right : b.right;
    d = (a.bottom < b.bottom) ? a.bottom : b.bottom;
    inter = box_span(l, r) * box_span(t, d);
    aa = area_of(a);
    ab = area_of(b);
    den = min_mode ? ((aa < ab) ? aa : ab) : (aa + ab - inter);
    if (den <= 0) return 0;
    return inter * 65536 >= longint'(thr) * den;
  endfunction

  // greedy selection over the closed set, queueing kept boxes in order
  task automatic suppress_set();
    bit    gone[MAX_BOXES];
    int    best;
    kept_t k;
    for (int i = 0; i < MAX_BOXES; i++) gone[i] = 0;
    forever begin
      best = -1;
      for (int i = 0; i < set_size; i++)
        if (!gone[i] && (best < 0 || set_boxes[i].score > set_boxes[best].score)) best = i;
      if (best < 0) break;
      gone[best] = 1;
      k.box = set_boxes[best];
      k.run_end = 0;
      k.overflow = set_dropped;
      kept_q = {kept_q, k};
      for (int i = 0; i < set_size; i++)
        if (!gone[i] && overlap_hits(set_boxes[best], set_boxes[i])) gone[i] = 1;
    end
    kept_q[kept_q.size()-1].run_end = 1;
    set_size = 0;
    set_dropped = 0;
  endtask

  always @(posedge clk) begin
    kept_t got, want;
    if (!rst_n) begin
      set_size <= 0;
      set_dropped <= 0;
      thr <= THR_RESET;
      min_mode <= 0;
      fail_count <= 0;
      kept_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_THRESHOLD) thr = cfg_data;
        else if (cfg_index == CFG_MODE) min_mode = cfg_data[0];
      end
      if (out_tvalid && out_tready) begin
        got.box = unpack_box(out_tdata);
        got.run_end = out_tlast;
        got.overflow = out_tuser;
        if (kept_q.size() == 0) begin
          $error("unexpected kept box %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = kept_q.pop_front();
          if (got != want) begin
            fail_count <= fail_count + 1;
            if (got.box.left != want.box.left)
              $error("kept_left exp %0d got %0d", want.box.left, got.box.left);
            if (got.box.top != want.box.top)
              $error("kept_top exp %0d got %0d", want.box.top, got.box.top);
            if (got.box.right != want.box.right)
              $error("kept_right exp %0d got %0d", want.box.right, got.box.right);
            if (got.box.bottom != want.box.bottom)
              $error("kept_bottom exp %0d got %0d", want.box.bottom, got.box.bottom);
            if (got.box.score != want.box.score)
              $error("kept_score exp %0d got %0d", want.box.score, got.box.score);
            if (got.run_end != want.run_end)
              $error("run_end exp %0d got %0d", want.run_end, got.run_end);
            if (got.overflow != want.overflow)
              $error("set_overflow exp %0d got %0d", want.overflow, got.overflow);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (set_size < MAX_BOXES) begin
          set_boxes[set_size] = unpack_box(in_tdata);
          set_size = set_size + 1;
        end else begin
          set_dropped = 1;
        end
        if (in_tlast) suppress_set();
      end
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for box non-maximum suppression
// random and directed box sets under several threshold and mode settings
// ----------------------------------------------------------------------------
module tb
  import nms_pkg::*;
;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          pending;
  int          fail_count;
  int          quiet_cycles;
  bit          calm;          // no idling on either side while set

  localparam int WATCHDOG = 200000;

  box_non_maximum_suppression u_top (.*);

  nms_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stalls at random, except during the calm stretch
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else out_tready <= calm || ($urandom_range(99) >= 35);
  end

  // watchdog on cycles with no accepted request anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // stop sending, wait for every kept box, then idle a while
  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // valid stays high after a request so that boxes can follow back to back
  task automatic send_box(input logic signed [12:0] l, t, r, b,
                          input logic [15:0] s, input bit last);
    if (!calm && $urandom_range(99) < 35) begin
      in_tvalid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < 35) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {4'd0, s, b, r, t, l};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // clustered boxes so that overlaps are common; occasional extremes
  task automatic random_set(input int n);
    logic signed [12:0] l, t, w, h;
    logic [15:0] s;
    int cx, cy;
    cx = $urandom_range(200) - 100;
    cy = $urandom_range(200) - 100;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        l = 13'($urandom); t = 13'($urandom); w = 13'($urandom); h = 13'($urandom);
        send_box(l, t, w, h, 16'($urandom), i == n - 1);
      end else begin
        l = 13'(cx + $urandom_range(20) - 10);
        t = 13'(cy + $urandom_range(20) - 10);
        w = 13'($urandom_range(30) - 2);
        h = 13'($urandom_range(30) - 2);
        s = ($urandom_range(3) == 0) ? 16'($urandom_range(3)) * 16'h4000 : 16'($urandom);
        send_box(l, t, l + w, t + h, s, i == n - 1);
      end
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tlast = 0;
    cfg_valid = 0;
    cfg_index = CFG_THRESHOLD;
    cfg_data = '0;
    calm = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: single box, extremes of every field, ties, empty boxes
    send_box(-13'sd4096, -13'sd4096, 13'sd4095, 13'sd4095, 16'hffff, 1'b1);
    send_box(13'sd4095, 13'sd4095, -13'sd4096, -13'sd4096, 16'h0000, 1'b0);
    send_box(13'sd0, 13'sd0, 13'sd9, 13'sd9, 16'h8000, 1'b0);
    send_box(13'sd0, 13'sd0, 13'sd9, 13'sd9, 16'h8000, 1'b0);
    send_box(13'sd5, 13'sd5, 13'sd14, 13'sd14, 16'h7fff, 1'b0);
    send_box(13'sd0, 13'sd0, -13'sd1, -13'sd1, 16'h9000, 1'b1);
    drain();
    write_reg(CFG_THRESHOLD, 16'd0);
    write_reg(CFG_MODE, 16'd1);
    write_reg(2'd3, 16'hffff);       // unknown index, ignored
    send_box(13'sd0, 13'sd0, 13'sd9, 13'sd9, 16'h1000, 1'b0);
    send_box(13'sd2, 13'sd2, 13'sd4, 13'sd4, 16'h2000, 1'b0);
    send_box(13'sd100, 13'sd100, 13'sd90, 13'sd90, 16'h3000, 1'b0);
    send_box(13'sd500, 13'sd500, 13'sd510, 13'sd510, 16'h0100, 1'b1);
    drain();
    write_reg(CFG_THRESHOLD, 16'hffff);
    // overflow: 66 boxes, the last two (the final one with tlast) are dropped
    random_set(66);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_THRESHOLD, (ph == 0) ? 16'd0 : (ph == 1) ? 16'hffff : 16'($urandom));
      write_reg(CFG_MODE, {15'd0, ph[0]});
      calm = (ph == 3);
      for (int k = 0; k < 4; k++)
        random_set($urandom_range(12) + 1);
      drain();
    end
    calm = 0;
    write_reg(CFG_THRESHOLD, THR_RESET);
    write_reg(CFG_MODE, 16'd0);
    random_set(20);

    drain();
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
